>>> sv/rgc_pkg.sv
// ---------------------------------------------------------------------------
// rgc_pkg
// Shared types and constants for the readability grade counter.
// ---------------------------------------------------------------------------
package rgc_pkg;

   // text bytes with a meaning of their own
   localparam logic [7:0] CH_APOS    = 8'h27;
   localparam logic [7:0] CH_PERIOD  = 8'h2E;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_QUERY   = 8'h3F;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_E = 8'h65;
   localparam logic [7:0] CH_LOWER_I = 8'h69;
   localparam logic [7:0] CH_LOWER_O = 8'h6F;
   localparam logic [7:0] CH_LOWER_U = 8'h75;
   localparam logic [7:0] CH_LOWER_Y = 8'h79;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_E = 8'h45;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;
   localparam logic [7:0] CASE_BIT   = 8'h20;

   // grade = -C0 + 39*W*2^F/(100*S) + 118*Y*2^F/(10*W)
   localparam int GRADE_W_COEF = 39;
   localparam int GRADE_W_DIV  = 100;
   localparam int GRADE_Y_COEF = 118;
   localparam int GRADE_Y_DIV  = 10;
   localparam int GRADE_C0_NUM = 1559;
   localparam int GRADE_C0_DEN = 100;

   // quotient terms are clamped here; any clamped term already saturates the grade
   localparam int          TERM_W   = 34;
   localparam logic [33:0] TERM_SAT = 34'h1_FFFF_FFFF;

   localparam logic [31:0] OUT_MAX   = 32'hFFFF_FFFF;
   localparam logic [31:0] GRADE_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] GRADE_MIN = 32'h8000_0000;

   localparam logic [1:0] QUEUE_DEPTH = 2'd2;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_DIV1,
      B_SAVE1,
      B_DIV2,
      B_SAVE2,
      B_DONE
   } back_state_type;

endpackage

>>> sv/rgc_queue.sv
// ---------------------------------------------------------------------------
// rgc_queue
// Two-entry queue of finished count snapshots between front and back.
// ---------------------------------------------------------------------------
module rgc_queue #(
   parameter int WIDTH = 96
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [WIDTH-1:0]         push_data,
   input  logic                     pop,
   output logic [WIDTH-1:0]         pop_data,
   output rgc_pkg::fifo_status_type status
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == rgc_pkg::QUEUE_DEPTH);
   assign status.empty = (count_ff == 2'd0);

endmodule

>>> sv/rgc_front.sv
// ---------------------------------------------------------------------------
// rgc_front
// Byte classifier and word, sentence and syllable counters.
// ---------------------------------------------------------------------------
module rgc_front #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_char_code,
   input  logic                         req_end_of_text,
   input  rgc_pkg::fifo_status_type     q_status,
   output logic                         q_push,
   output logic [3*COUNT_WIDTH-1:0]     q_data
);

   logic                   inside_ff, inside_in;
   logic                   letter_ff, letter_in;
   logic                   acv_ff, acv_in;
   logic                   prev_e_ff, prev_e_in;
   logic [COUNT_WIDTH-1:0] cws_ff, cws_in;
   logic [COUNT_WIDTH-1:0] words_ff, words_in;
   logic [COUNT_WIDTH-1:0] sents_ff, sents_in;
   logic [COUNT_WIDTH-1:0] syls_ff, syls_in;

   logic                   accept;
   logic                   word_char;
   logic                   start;
   logic                   letter_cur;
   logic                   acv_cur;
   logic [COUNT_WIDTH-1:0] cws_cur;
   logic                   count_vowel;
   logic [COUNT_WIDTH-1:0] cws_upd;
   logic                   pe_upd;
   logic                   f_inside, f_letter, f_pe;
   logic [COUNT_WIDTH-1:0] f_cws;
   logic                   counted;
   logic [COUNT_WIDTH-1:0] syl_word;
   logic [COUNT_WIDTH-1:0] words_upd, sents_upd, syls_upd;
   logic [COUNT_WIDTH:0]   syl_sum;

   function automatic logic is_letter(input logic [7:0] c);
      is_letter = (c >= rgc_pkg::CH_LOWER_A && c <= rgc_pkg::CH_LOWER_Z) ||
                  (c >= rgc_pkg::CH_UPPER_A && c <= rgc_pkg::CH_UPPER_Z);
   endfunction

   function automatic logic is_word_char(input logic [7:0] c);
      is_word_char = is_letter(c) || c == rgc_pkg::CH_APOS ||
                     (c >= rgc_pkg::CH_DIGIT_0 && c <= rgc_pkg::CH_DIGIT_9);
   endfunction

   function automatic logic is_vowel(input logic [7:0] c);
      logic [7:0] l;
      l = (c >= rgc_pkg::CH_UPPER_A && c <= rgc_pkg::CH_UPPER_Z) ?
          (c | rgc_pkg::CASE_BIT) : c;
      is_vowel = l == rgc_pkg::CH_LOWER_A || l == rgc_pkg::CH_LOWER_E ||
                 l == rgc_pkg::CH_LOWER_I || l == rgc_pkg::CH_LOWER_O ||
                 l == rgc_pkg::CH_LOWER_U || l == rgc_pkg::CH_LOWER_Y;
   endfunction

   function automatic logic is_sentence(input logic [7:0] c);
      is_sentence = c == rgc_pkg::CH_PERIOD || c == rgc_pkg::CH_BANG ||
                    c == rgc_pkg::CH_QUERY;
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      sat_inc = (v == '1) ? v : v + COUNT_WIDTH'(1);
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] at_least_one(input logic [COUNT_WIDTH-1:0] v);
      at_least_one = (v == '0) ? COUNT_WIDTH'(1) : v;
   endfunction

   always_comb begin
      accept      = req_valid && !req_stall;
      word_char   = is_word_char(req_char_code);
      start       = word_char && !inside_ff;
      letter_cur  = start ? is_letter(req_char_code) : letter_ff;
      acv_cur     = start ? 1'b0 : acv_ff;
      cws_cur     = start ? '0 : cws_ff;
      count_vowel = is_vowel(req_char_code) && !acv_cur;
      cws_upd     = count_vowel ? sat_inc(cws_cur) : cws_cur;
      pe_upd      = (req_char_code == rgc_pkg::CH_LOWER_E) ||
                    (req_char_code == rgc_pkg::CH_UPPER_E);

      // word closes on a non-word byte (old state) or on the last byte (updated state)
      f_inside = word_char ? 1'b1 : inside_ff;
      f_letter = word_char ? letter_cur : letter_ff;
      f_cws    = word_char ? cws_upd : cws_ff;
      f_pe     = word_char ? pe_upd : prev_e_ff;
      counted  = (!word_char || req_end_of_text) && f_inside && f_letter;

      // silent final e
      syl_word = (f_pe && f_cws > COUNT_WIDTH'(1)) ? f_cws - COUNT_WIDTH'(1) : f_cws;
      syl_sum  = {1'b0, syls_ff} + {1'b0, syl_word};

      words_upd = counted ? sat_inc(words_ff) : words_ff;
      syls_upd  = !counted ? syls_ff : (syl_sum[COUNT_WIDTH] ? '1 : syl_sum[COUNT_WIDTH-1:0]);
      sents_upd = (!word_char && is_sentence(req_char_code)) ? sat_inc(sents_ff) : sents_ff;
   end

   always_comb begin
      inside_in = inside_ff;
      letter_in = letter_ff;
      acv_in    = acv_ff;
      prev_e_in = prev_e_ff;
      cws_in    = cws_ff;
      words_in  = words_ff;
      sents_in  = sents_ff;
      syls_in   = syls_ff;
      if (accept) begin
         if (req_end_of_text) begin
            inside_in = 1'b0;
            letter_in = 1'b0;
            acv_in    = 1'b0;
            prev_e_in = 1'b0;
            cws_in    = '0;
            words_in  = '0;
            sents_in  = '0;
            syls_in   = '0;
         end else begin
            if (word_char) begin
               inside_in = 1'b1;
               letter_in = letter_cur;
               acv_in    = count_vowel;
               prev_e_in = pe_upd;
               cws_in    = cws_upd;
            end else begin
               inside_in = 1'b0;
               letter_in = 1'b0;
               acv_in    = 1'b0;
               prev_e_in = 1'b0;
               cws_in    = '0;
            end
            words_in = words_upd;
            sents_in = sents_upd;
            syls_in  = syls_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         letter_ff <= 1'b0;
         acv_ff    <= 1'b0;
         prev_e_ff <= 1'b0;
         cws_ff    <= '0;
         words_ff  <= '0;
         sents_ff  <= '0;
         syls_ff   <= '0;
      end else begin
         inside_ff <= inside_in;
         letter_ff <= letter_in;
         acv_ff    <= acv_in;
         prev_e_ff <= prev_e_in;
         cws_ff    <= cws_in;
         words_ff  <= words_in;
         sents_ff  <= sents_in;
         syls_ff   <= syls_in;
      end
   end

   assign req_stall = q_status.full;
   assign q_push    = accept && req_end_of_text;
   assign q_data    = {at_least_one(words_upd), at_least_one(sents_upd), syls_upd};

endmodule

>>> sv/rgc_back.sv
// ---------------------------------------------------------------------------
// rgc_back
// Grade sequencer: shared restoring divider, grade sum and result register.
// ---------------------------------------------------------------------------
module rgc_back #(
   parameter int COUNT_WIDTH   = 32,
   parameter int FRACTION_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rgc_pkg::fifo_status_type q_status,
   input  logic [3*COUNT_WIDTH-1:0] q_data,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [31:0]              rsp_word_count,
   output logic [31:0]              rsp_sentence_count,
   output logic [31:0]              rsp_syllable_count,
   output logic signed [31:0]       rsp_grade_level_q8
);

   localparam int NUM_W = COUNT_WIDTH + 7 + FRACTION_BITS;
   localparam int DEN_W = COUNT_WIDTH + 7;
   localparam int CNT_W = $clog2(NUM_W);
   localparam int QX    = (NUM_W > rgc_pkg::TERM_W) ? NUM_W : rgc_pkg::TERM_W;
   localparam int EXT_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
   localparam logic [35:0] GRADE_OFFSET =
      36'((rgc_pkg::GRADE_C0_NUM * (1 << FRACTION_BITS)) / rgc_pkg::GRADE_C0_DEN);

   rgc_pkg::back_state_type state_ff, state_in;

   logic [COUNT_WIDTH-1:0] w_ff, s_ff, y_ff;
   logic [NUM_W-1:0]       num_ff, num_in;
   logic [DEN_W-1:0]       rem_ff, rem_in;
   logic [DEN_W-1:0]       den_ff, den_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [33:0]            t1_ff;
   logic [34:0]            sum_ff;

   logic                   rsp_valid_ff;
   logic [31:0]            word_ff, sent_ff, syl_ff;
   logic [31:0]            grade_ff, grade_in;

   logic                   init1, step, save1, save2, load_out, out_free, last_step;
   logic [DEN_W:0]         trial, diff;
   logic                   ge;
   logic signed [35:0]     grade_diff;
   logic [COUNT_WIDTH-1:0] head_w, head_s, head_y;

   function automatic logic [31:0] clamp_out(input logic [COUNT_WIDTH-1:0] v);
      logic [EXT_W-1:0] ext;
      ext = EXT_W'(v);
      clamp_out = (ext > EXT_W'(rgc_pkg::OUT_MAX)) ? rgc_pkg::OUT_MAX : ext[31:0];
   endfunction

   function automatic logic [33:0] clamp_term(input logic [NUM_W-1:0] q);
      logic [QX-1:0] ext;
      ext = QX'(q);
      clamp_term = (ext[QX-1:33] != '0) ? rgc_pkg::TERM_SAT : ext[33:0];
   endfunction

   assign {head_w, head_s, head_y} = q_data;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_step = (cnt_ff == CNT_W'(NUM_W - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rgc_pkg::B_IDLE:  if (!q_status.empty) state_in = rgc_pkg::B_DIV1;
         rgc_pkg::B_DIV1:  if (last_step) state_in = rgc_pkg::B_SAVE1;
         rgc_pkg::B_SAVE1: state_in = rgc_pkg::B_DIV2;
         rgc_pkg::B_DIV2:  if (last_step) state_in = rgc_pkg::B_SAVE2;
         rgc_pkg::B_SAVE2: state_in = rgc_pkg::B_DONE;
         rgc_pkg::B_DONE:  if (out_free) state_in = rgc_pkg::B_IDLE;
         default:          state_in = rgc_pkg::B_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      init1    = 1'b0;
      step     = 1'b0;
      save1    = 1'b0;
      save2    = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         rgc_pkg::B_IDLE:  init1 = !q_status.empty;
         rgc_pkg::B_DIV1,
         rgc_pkg::B_DIV2:  step = 1'b1;
         rgc_pkg::B_SAVE1: save1 = 1'b1;
         rgc_pkg::B_SAVE2: save2 = 1'b1;
         rgc_pkg::B_DONE:  load_out = out_free;
         default:          init1 = 1'b0;
      endcase
   end

   assign q_pop = init1;

   // one restoring division step per cycle
   always_comb begin
      trial = {rem_ff, num_ff[NUM_W-1]};
      ge    = trial >= {1'b0, den_ff};
      diff  = trial - {1'b0, den_ff};
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      if (init1) begin
         num_in = (NUM_W'(head_w) * NUM_W'(rgc_pkg::GRADE_W_COEF)) << FRACTION_BITS;
         den_in = DEN_W'(head_s) * DEN_W'(rgc_pkg::GRADE_W_DIV);
         rem_in = '0;
         cnt_in = '0;
      end else if (save1) begin
         num_in = (NUM_W'(y_ff) * NUM_W'(rgc_pkg::GRADE_Y_COEF)) << FRACTION_BITS;
         den_in = DEN_W'(w_ff) * DEN_W'(rgc_pkg::GRADE_Y_DIV);
         rem_in = '0;
         cnt_in = '0;
      end else if (step) begin
         num_in = {num_ff[NUM_W-2:0], ge};
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_comb begin
      grade_diff = $signed({1'b0, sum_ff}) - $signed(GRADE_OFFSET);
      if (grade_diff > $signed(36'h0_7FFF_FFFF)) begin
         grade_in = rgc_pkg::GRADE_MAX;
      end else if (grade_diff < $signed(36'hF_8000_0000)) begin
         grade_in = rgc_pkg::GRADE_MIN;
      end else begin
         grade_in = grade_diff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rgc_pkg::B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (init1) begin
         w_ff <= head_w;
         s_ff <= head_s;
         y_ff <= head_y;
      end
      if (save1) begin
         t1_ff <= clamp_term(num_ff);
      end
      if (save2) begin
         sum_ff <= 35'(t1_ff) + 35'(clamp_term(num_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         word_ff  <= clamp_out(w_ff);
         sent_ff  <= clamp_out(s_ff);
         syl_ff   <= clamp_out(y_ff);
         grade_ff <= grade_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_word_count     = word_ff;
   assign rsp_sentence_count = sent_ff;
   assign rsp_syllable_count = syl_ff;
   assign rsp_grade_level_q8 = $signed(grade_ff);

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rgc_pkg::B_DIV1 || state_ff == rgc_pkg::B_DIV2) |-> den_ff != '0)
      else $error("divider running with a zero divisor");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rgc_pkg::B_DIV1 || state_ff == rgc_pkg::B_DIV2) |-> rem_ff < den_ff)
      else $error("partial remainder not below divisor");

   a_div_starts_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rgc_pkg::B_IDLE && !q_status.empty) |=>
         (state_ff == rgc_pkg::B_DIV1 && cnt_ff == '0 && rem_ff == '0))
      else $error("division did not start from a cleared step count");

endmodule

>>> sv/readability_grade_counter_top.sv
// ---------------------------------------------------------------------------
// readability_grade_counter_top
// Flesch-Kincaid grade level counter over a byte stream, Q8 grade output.
// ---------------------------------------------------------------------------
//   channel  | direction | ports                       | transfer when
//   ---------+-----------+-----------------------------+----------------------
//   req      | in        | char_code, end_of_text      | req_valid & !req_stall
//   rsp      | out       | word/sentence/syllable cnt, | rsp_valid & !rsp_stall
//            |           | grade_level_q8              |
//
// text bytes take one cycle each while req_stall is low; the front keeps counting while a grade is computed
// a last byte hands its counts to a two-entry queue; req_stall rises only when it is full
// each grade goes through the back states B_IDLE, B_DIV1, B_SAVE1, B_DIV2, B_SAVE2, B_DONE,
// using one restoring divider shared by both quotient terms, one bit a cycle
// synchronous reset clears the front's counters, the queue and the result valid flag
// the result is held in an output register while rsp_stall is high
// ---------------------------------------------------------------------------
module readability_grade_counter_top #(
   parameter int COUNT_WIDTH   = 32,
   parameter int FRACTION_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_char_code,
   input  logic               req_end_of_text,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_word_count,
   output logic [31:0]        rsp_sentence_count,
   output logic [31:0]        rsp_syllable_count,
   output logic signed [31:0] rsp_grade_level_q8
);

   localparam int Q_W = 3 * COUNT_WIDTH;

   rgc_pkg::fifo_status_type q_status;
   logic                     q_push;
   logic                     q_pop;
   logic [Q_W-1:0]           q_push_data;
   logic [Q_W-1:0]           q_pop_data;

   rgc_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_code   (req_char_code),
      .req_end_of_text (req_end_of_text),
      .q_status        (q_status),
      .q_push          (q_push),
      .q_data          (q_push_data)
   );

   rgc_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   rgc_back #(
      .COUNT_WIDTH   (COUNT_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_status           (q_status),
      .q_data             (q_pop_data),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_word_count     (rsp_word_count),
      .rsp_sentence_count (rsp_sentence_count),
      .rsp_syllable_count (rsp_syllable_count),
      .rsp_grade_level_q8 (rsp_grade_level_q8)
   );

endmodule

>>> dv/readability_grade_counter_top_tb.sv
// ---------------------------------------------------------------------------
// readability_grade_counter_top_tb
// Self-checking bench: streams text bytes into the grade counter, predicts
// the word, sentence and syllable counts and the Q8 grade of every text, and
// compares each result in order. Directed texts first, then random texts with
// idle cycles on both sides and one long receiver hold-off after a full drain.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module readability_grade_counter_top_tb;

   localparam int COUNT_BITS   = 32;
   localparam int FRAC_BITS    = 8;
   localparam int IDLE_PCT     = 28;
   localparam int RANDOM_ITEMS = 1500;
   localparam int HOLD_CYCLES  = 400;
   localparam int TAIL_CYCLES  = 150;
   localparam int QUIET_LIMIT  = 4000;

   localparam logic [63:0]  COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
   localparam logic [127:0] LIMIT64   = {64'd0, {64{1'b1}}};

   typedef struct packed {
      logic [31:0]        words;
      logic [31:0]        sentences;
      logic [31:0]        syllables;
      logic signed [31:0] grade;
   } grade_report_type;

   typedef struct packed {
      logic [7:0]       code;
      logic             last;
      logic             known;
      grade_report_type want;
   } text_probe_type;

   // an empty text counts as one word and one sentence
   localparam grade_report_type EMPTY_TEXT = '{32'd1, 32'd1, 32'd0, -32'sd3892};
   localparam grade_report_type ONE_VOWEL  = '{32'd1, 32'd1, 32'd1, -32'sd872};
   localparam grade_report_type NO_REPORT  = '0;

   localparam logic [7:0] VOWEL_LOWER [6] = '{
      rgc_pkg::CH_LOWER_A, rgc_pkg::CH_LOWER_E, rgc_pkg::CH_LOWER_I,
      rgc_pkg::CH_LOWER_O, rgc_pkg::CH_LOWER_U, rgc_pkg::CH_LOWER_Y};

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [7:0]         req_char_code;
   logic               req_end_of_text;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [31:0]        rsp_word_count;
   logic [31:0]        rsp_sentence_count;
   logic [31:0]        rsp_syllable_count;
   logic signed [31:0] rsp_grade_level_q8;

   // predicted text state
   logic        in_word         = 1'b0;
   logic        word_is_counted = 1'b0;
   logic        vowel_run       = 1'b0;
   logic        ended_in_e      = 1'b0;
   logic [63:0] word_syl        = '0;
   logic [63:0] words_total     = '0;
   logic [63:0] marks_total     = '0;
   logic [63:0] syl_total       = '0;

   grade_report_type pending_grades [$];

   int mismatch_count = 0;
   int bytes_sent     = 0;
   int texts_done     = 0;
   int grades_seen    = 0;
   int hold_requests  = 0;
   int holds_served   = 0;
   bit calm           = 1'b0;

   text_probe_type directed_text [26] = '{
      '{8'h00, 1'b1, 1'b1, EMPTY_TEXT},
      '{8'hFF, 1'b1, 1'b1, EMPTY_TEXT},
      '{rgc_pkg::CH_PERIOD, 1'b1, 1'b1, EMPTY_TEXT},
      '{rgc_pkg::CH_LOWER_A, 1'b1, 1'b1, ONE_VOWEL},
      // silent e, vowel pair, digit word, apostrophe word, y vowel
      '{"T", 1'b0, 1'b0, NO_REPORT},
      '{"a", 1'b0, 1'b0, NO_REPORT},
      '{"k", 1'b0, 1'b0, NO_REPORT},
      '{"e", 1'b0, 1'b0, NO_REPORT},
      '{rgc_pkg::CH_SPACE, 1'b0, 1'b0, NO_REPORT},
      '{"b", 1'b0, 1'b0, NO_REPORT},
      '{"o", 1'b0, 1'b0, NO_REPORT},
      '{"a", 1'b0, 1'b0, NO_REPORT},
      '{"t", 1'b0, 1'b0, NO_REPORT},
      '{rgc_pkg::CH_TAB, 1'b0, 1'b0, NO_REPORT},
      '{"9", 1'b0, 1'b0, NO_REPORT},
      '{"a", 1'b0, 1'b0, NO_REPORT},
      '{"e", 1'b0, 1'b0, NO_REPORT},
      '{8'h0B, 1'b0, 1'b0, NO_REPORT},
      '{rgc_pkg::CH_APOS, 1'b0, 1'b0, NO_REPORT},
      '{"Y", 1'b0, 1'b0, NO_REPORT},
      '{"E", 1'b0, 1'b0, NO_REPORT},
      '{"s", 1'b0, 1'b0, NO_REPORT},
      '{rgc_pkg::CH_BANG, 1'b0, 1'b0, NO_REPORT},
      '{8'h80, 1'b0, 1'b0, NO_REPORT},
      '{rgc_pkg::CH_LOWER_Y, 1'b0, 1'b0, NO_REPORT},
      '{rgc_pkg::CH_UPPER_E, 1'b1, 1'b0, NO_REPORT}
   };

   readability_grade_counter_top #(
      .COUNT_WIDTH   (COUNT_BITS),
      .FRACTION_BITS (FRAC_BITS)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_code      (req_char_code),
      .req_end_of_text    (req_end_of_text),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_word_count     (rsp_word_count),
      .rsp_sentence_count (rsp_sentence_count),
      .rsp_syllable_count (rsp_syllable_count),
      .rsp_grade_level_q8 (rsp_grade_level_q8)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("mismatch in %s at %0t: got %0h, expected %0h", what, $time, got, want);
   endtask

   function automatic void close_word();
      logic [63:0] syl;
      if (in_word && word_is_counted) begin
         syl = word_syl;
         if (ended_in_e && syl > 64'd1) syl = syl - 64'd1;
         words_total = (words_total >= COUNT_MAX) ? COUNT_MAX : words_total + 64'd1;
         syl_total   = (syl_total + syl > COUNT_MAX) ? COUNT_MAX : syl_total + syl;
      end
      in_word         = 1'b0;
      word_is_counted = 1'b0;
      vowel_run       = 1'b0;
      ended_in_e      = 1'b0;
      word_syl        = '0;
   endfunction

   // returns 1 when the byte closes a text, with the expected result in rep
   function automatic bit tally_byte(input logic [7:0] c, input logic last,
                                     output grade_report_type rep);
      logic         upper;
      logic         letter;
      logic         vowel;
      logic [7:0]   folded;
      logic [127:0] w, s, y, c0, t1, t2, total, gap;
      upper  = c >= rgc_pkg::CH_UPPER_A && c <= rgc_pkg::CH_UPPER_Z;
      letter = upper || (c >= rgc_pkg::CH_LOWER_A && c <= rgc_pkg::CH_LOWER_Z);
      folded = upper ? (c | rgc_pkg::CASE_BIT) : c;
      vowel  = folded == rgc_pkg::CH_LOWER_A || folded == rgc_pkg::CH_LOWER_E ||
               folded == rgc_pkg::CH_LOWER_I || folded == rgc_pkg::CH_LOWER_O ||
               folded == rgc_pkg::CH_LOWER_U || folded == rgc_pkg::CH_LOWER_Y;
      rep = '0;
      if (letter || (c >= rgc_pkg::CH_DIGIT_0 && c <= rgc_pkg::CH_DIGIT_9) ||
          c == rgc_pkg::CH_APOS) begin
         if (!in_word) begin
            in_word         = 1'b1;
            word_is_counted = letter;
            vowel_run       = 1'b0;
            word_syl        = '0;
         end
         if (vowel && !vowel_run) begin
            word_syl  = (word_syl >= COUNT_MAX) ? COUNT_MAX : word_syl + 64'd1;
            vowel_run = 1'b1;
         end else begin
            vowel_run = 1'b0;
         end
         ended_in_e = folded == rgc_pkg::CH_LOWER_E;
      end else begin
         close_word();
         if (c == rgc_pkg::CH_PERIOD || c == rgc_pkg::CH_BANG ||
             c == rgc_pkg::CH_QUERY) begin
            marks_total = (marks_total >= COUNT_MAX) ? COUNT_MAX : marks_total + 64'd1;
         end
      end
      if (!last) return 1'b0;

      close_word();
      w  = (words_total == 0) ? 128'd1 : 128'(words_total);
      s  = (marks_total == 0) ? 128'd1 : 128'(marks_total);
      y  = 128'(syl_total);
      c0 = 128'((rgc_pkg::GRADE_C0_NUM << FRAC_BITS) / rgc_pkg::GRADE_C0_DEN);
      t1 = ((w * rgc_pkg::GRADE_W_COEF) << FRAC_BITS) / (s * rgc_pkg::GRADE_W_DIV);
      t2 = ((y * rgc_pkg::GRADE_Y_COEF) << FRAC_BITS) / (w * rgc_pkg::GRADE_Y_DIV);
      if (t1 > LIMIT64) t1 = LIMIT64;
      if (t2 > LIMIT64) t2 = LIMIT64;
      total = t1 + t2;
      if (total > LIMIT64) total = LIMIT64;
      if (total >= c0) begin
         gap       = total - c0;
         rep.grade = (gap > 128'(rgc_pkg::GRADE_MAX)) ? rgc_pkg::GRADE_MAX : gap[31:0];
      end else begin
         gap       = c0 - total;
         rep.grade = (gap > 128'(rgc_pkg::GRADE_MIN)) ? rgc_pkg::GRADE_MIN :
                     ~gap[31:0] + 32'd1;
      end
      rep.words     = (w > 128'(rgc_pkg::OUT_MAX)) ? rgc_pkg::OUT_MAX : w[31:0];
      rep.sentences = (s > 128'(rgc_pkg::OUT_MAX)) ? rgc_pkg::OUT_MAX : s[31:0];
      rep.syllables = (y > 128'(rgc_pkg::OUT_MAX)) ? rgc_pkg::OUT_MAX : y[31:0];
      words_total = '0;
      marks_total = '0;
      syl_total   = '0;
      return 1'b1;
   endfunction

   function automatic logic [7:0] pick_text_byte();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 32) return 8'($urandom_range(rgc_pkg::CH_LOWER_A, rgc_pkg::CH_LOWER_Z));
      if (roll < 48) return VOWEL_LOWER[$urandom_range(0, 5)] &
                            ~($urandom_range(0, 1) ? rgc_pkg::CASE_BIT : 8'h00);
      // extra e's so that words often end in one
      if (roll < 53) return $urandom_range(0, 1) ? rgc_pkg::CH_LOWER_E : rgc_pkg::CH_UPPER_E;
      if (roll < 60) return 8'($urandom_range(rgc_pkg::CH_UPPER_A, rgc_pkg::CH_UPPER_Z));
      if (roll < 65) return 8'($urandom_range(rgc_pkg::CH_DIGIT_0, rgc_pkg::CH_DIGIT_9));
      if (roll < 67) return rgc_pkg::CH_APOS;
      if (roll < 78) return rgc_pkg::CH_SPACE;
      if (roll < 81) return 8'($urandom_range(rgc_pkg::CH_TAB, rgc_pkg::CH_CR));
      if (roll < 89) begin
         case ($urandom_range(0, 2))
            0:       return rgc_pkg::CH_PERIOD;
            1:       return rgc_pkg::CH_BANG;
            default: return rgc_pkg::CH_QUERY;
         endcase
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic offer_byte(input logic [7:0] code, input logic last);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid     <= 1'b0;
         req_char_code <= 8'($urandom);
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_char_code   <= code;
      req_end_of_text <= last;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input int len);
      grade_report_type rep;
      logic [7:0]       c;
      for (int k = 1; k <= len; k++) begin
         c = pick_text_byte();
         offer_byte(c, k == len);
         if (tally_byte(c, k == len, rep)) pending_grades.push_back(rep);
      end
      texts_done++;
   endtask

   always @(posedge clock) begin : grade_check
      grade_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         grades_seen++;
         if (pending_grades.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_word_count, '0);
         end else begin
            want = pending_grades.pop_front();
            if (rsp_word_count !== want.words)
               report_mismatch("word_count", rsp_word_count, want.words);
            if (rsp_sentence_count !== want.sentences)
               report_mismatch("sentence_count", rsp_sentence_count, want.sentences);
            if (rsp_syllable_count !== want.syllables)
               report_mismatch("syllable_count", rsp_syllable_count, want.syllables);
            if (rsp_grade_level_q8 !== want.grade)
               report_mismatch("grade_level_q8", rsp_grade_level_q8, want.grade);
         end
      end
   end

   initial begin : rsp_side
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served < hold_requests) begin
            // long hold-off so the result queue fills and the input stalls
            rsp_stall <= 1'b1;
            holds_served++;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : text_source
      grade_report_type rep;
      int               sent;
      int               len;
      int               roll;
      bit               pressure_done;
      sent          = 0;
      pressure_done = 1'b0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_char_code   <= '0;
      req_end_of_text <= 1'b0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_text[i]) begin
         offer_byte(directed_text[i].code, directed_text[i].last);
         if (tally_byte(directed_text[i].code, directed_text[i].last, rep))
            pending_grades.push_back(directed_text[i].known ? directed_text[i].want : rep);
      end

      while (sent < RANDOM_ITEMS) begin
         if (!pressure_done && sent >= 500) begin
            // drain everything, then keep short texts coming into a held receiver
            req_valid <= 1'b0;
            while (pending_grades.size() != 0) @(negedge clock);
            calm = 1'b1;
            hold_requests++;
            repeat (12) send_text($urandom_range(1, 3));
            calm          = 1'b0;
            pressure_done = 1'b1;
         end
         calm = sent >= 900 && sent < 1150;
         roll = $urandom_range(0, 99);
         if (roll < 3) len = $urandom_range(150, 300);
         else if (roll < 15) len = $urandom_range(30, 100);
         else len = $urandom_range(1, 30);
         if (len > RANDOM_ITEMS - sent) len = RANDOM_ITEMS - sent;
         send_text(len);
         sent += len;
      end
      calm = 1'b0;

      req_valid <= 1'b0;
      while (pending_grades.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d texts in %0d bytes, %0d grades compared", texts_done + 4 + 1,
               bytes_sent, grades_seen);
      $display("random bytes, idle gaps on both sides, %0d long receiver hold-off(s)",
               holds_served);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
